/* design/kwq_pkg.sv */
package kwq_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 8;

    // Fixed field widths
    localparam int OP_W     = 3;
    localparam int ST_W     = 3;
    localparam int STATUS_W = 2;
    localparam int OUT_ID_W = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_TAKE   = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

    // Register file
    localparam int                  APB_DATA_W     = 32;
    localparam int                  APB_ADDR_W     = 3;
    localparam logic [APB_ADDR_W-1:0] ADDR_WAIT_CODE = 3'd0;
    localparam logic [ST_W-1:0]     WAIT_CODE_RST  = 3'd1;

    // Command broadcast to every cell
    typedef enum logic [2:0] {
        CK_NONE,
        CK_APPEND,
        CK_DEL_ID,
        CK_DEL_WAIT,
        CK_UPDATE
    } t_cell_kind;

    typedef struct packed {
        t_cell_kind      kind;
        logic [ST_W-1:0] set_state;
        logic [ST_W-1:0] wait_code;
    } t_cell_cmd;

endpackage

/* design/kwq_in_if.sv */
interface kwq_in_if #(
    parameter int ID_W = kwq_pkg::ID_BITS_DEF
) ();
    logic                      valid;
    logic                      ready;
    logic [kwq_pkg::OP_W-1:0]  op;
    logic [ID_W-1:0]           thread_id;
    logic [kwq_pkg::ST_W-1:0]  set_state;

    modport source (output valid, op, thread_id, set_state, input ready);
    modport sink   (input valid, op, thread_id, set_state, output ready);
endinterface

/* design/kwq_out_if.sv */
interface kwq_out_if #(
    parameter int CNT_W = $clog2(kwq_pkg::DEPTH_DEF + 1)
) ();
    logic                          valid;
    logic                          ready;
    logic [kwq_pkg::STATUS_W-1:0]  status;
    logic [kwq_pkg::OUT_ID_W-1:0]  result_thread;
    logic [kwq_pkg::ST_W-1:0]      result_state;
    logic                          found;
    logic                          queue_empty;
    logic [CNT_W-1:0]              entry_count;
    logic [kwq_pkg::OUT_ID_W-1:0]  front_thread;
    logic [kwq_pkg::OUT_ID_W-1:0]  first_waiting;
    logic                          first_waiting_valid;

    modport source (output valid, status, result_thread, result_state, found, queue_empty,
                    entry_count, front_thread, first_waiting, first_waiting_valid,
                    input ready);
    modport sink   (input valid, status, result_thread, result_state, found, queue_empty,
                    entry_count, front_thread, first_waiting, first_waiting_valid,
                    output ready);
endinterface

/* design/keyed_wait_queue.sv */
// Ordered wait queue of up to DEPTH thread entries (id plus 3-bit wait state), oldest
// first, held in a row of cells. Each input transfer carries one operation: append,
// take the oldest entry whose state equals the waiting code, remove by id, update the
// state by id, or look up by id; by-id operations act on the oldest matching entry and
// removal closes the gap, keeping order. Every operation yields exactly one result
// transfer with a status (ok, empty, not found, full) and a summary of the queue after
// the operation: count, empty flag, front id and oldest waiting id. Flow: an item
// passes through the execute step (cells compare, the oldest-match chain runs
// through the row and the cells shift or write) and then the summary step
// (the waiting chain runs again over the new contents and fills the output register),
// which waits for a free output register; the match chain along the cell row is
// used twice per item. A new item is taken in the cycle its predecessor's result
// is registered; the output register then waits on its own for the sink. The waiting
// code sits at byte address 0 of the APB port and may only be changed while idle.
// No clearing pass is needed after reset: cells beyond the count are never read.
module keyed_wait_queue #(
    parameter int DEPTH   = kwq_pkg::DEPTH_DEF,
    parameter int ID_BITS = kwq_pkg::ID_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    kwq_in_if.sink                            i_in,
    kwq_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kwq_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [kwq_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [kwq_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import kwq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = ID_BITS + OUT_ID_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;

    // control
    logic [1:0]       r_fsm, n_fsm;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    logic [ST_W-1:0]  r_wait_code;

    // latched operation
    logic [OP_W-1:0]    r_op;
    logic [ID_BITS-1:0] r_id;
    logic [ST_W-1:0]    r_set_state;

    // execute-step results, held for the summary step
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [ID_BITS-1:0]  r_res_thread, n_res_thread;
    logic [ST_W-1:0]     r_res_state, n_res_state;
    logic                r_res_found, n_res_found;

    // output register
    logic [STATUS_W-1:0] r_o_status;
    logic [OUT_ID_W-1:0] r_o_rthread;
    logic [ST_W-1:0]     r_o_rstate;
    logic                r_o_found;
    logic                r_o_empty;
    logic [CNT_W-1:0]    r_o_count;
    logic [OUT_ID_W-1:0] r_o_front;
    logic [OUT_ID_W-1:0] r_o_fwait;
    logic                r_o_fwait_valid;

    t_cell_cmd cmd;
    logic      in_xfer;
    logic      sum_go;
    logic      cfg_wr;
    logic      cfg_sel;
    logic      q_empty;
    logic      q_full;

    // cell row and its chains; index DEPTH is the far end of the chain
    logic [ID_BITS-1:0] c_thread [DEPTH];
    logic [ST_W-1:0]    c_state  [DEPTH];
    logic [DEPTH:0]     seen_id;
    logic [DEPTH:0]     seen_wait;
    logic [ID_BITS-1:0] w_thr    [DEPTH+1];
    logic [ST_W-1:0]    id_st    [DEPTH+1];

    logic [ID_BITS-1:0] front_id;
    logic [EXT_W-1:0]   ext_front;
    logic [EXT_W-1:0]   ext_fwait;
    logic [EXT_W-1:0]   ext_rthread;

    assign seen_id[0]   = 1'b0;
    assign seen_wait[0] = 1'b0;
    assign w_thr[0]     = '0;
    assign id_st[0]     = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ID_BITS-1:0] nxt_thread;
        logic [ST_W-1:0]    nxt_state;

        // the last cell has no neighbour; it only shifts beyond the count
        if (g == DEPTH - 1) begin : g_last
            assign nxt_thread = c_thread[g];
            assign nxt_state  = c_state[g];
        end else begin : g_mid
            assign nxt_thread = c_thread[g+1];
            assign nxt_state  = c_state[g+1];
        end

        kwq_cell #(
            .ID_W  (ID_BITS),
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cmd),
            .i_count       (r_count),
            .i_id          (r_id),
            .i_next_thread (nxt_thread),
            .i_next_state  (nxt_state),
            .i_seen_id     (seen_id[g]),
            .i_seen_wait   (seen_wait[g]),
            .i_wait_thread (w_thr[g]),
            .i_id_state    (id_st[g]),
            .o_thread      (c_thread[g]),
            .o_state       (c_state[g]),
            .o_seen_id     (seen_id[g+1]),
            .o_seen_wait   (seen_wait[g+1]),
            .o_wait_thread (w_thr[g+1]),
            .o_id_state    (id_st[g+1])
        );
    end

    assign q_empty = r_count == '0;
    assign q_full  = r_count == CNT_W'(DEPTH);

    // summary step completes once the output register is free; nothing taken in reset
    assign sum_go  = (r_fsm == ST_SUM) && (!r_out_valid || o_out.ready);
    assign i_in.ready = i_rst_n && ((r_fsm == ST_IDLE) || sum_go);
    assign in_xfer = i_in.valid && i_in.ready;

    // execute step: decode, drive the row, settle status and new count
    always_comb begin
        cmd.kind      = CK_NONE;
        cmd.set_state = r_set_state;
        cmd.wait_code = r_wait_code;
        n_count       = r_count;
        n_res_status  = STATUS_OK;
        n_res_thread  = '0;
        n_res_state   = '0;
        n_res_found   = 1'b0;
        if (r_fsm == ST_EXEC) begin
            unique case (r_op)
                OP_APPEND: begin
                    if (q_full) begin
                        n_res_status = STATUS_FULL;
                    end else begin
                        cmd.kind = CK_APPEND;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
                OP_TAKE: begin
                    if (q_empty) begin
                        n_res_status = STATUS_EMPTY;
                    end else if (seen_wait[DEPTH]) begin
                        cmd.kind     = CK_DEL_WAIT;
                        n_count      = r_count - CNT_W'(1);
                        n_res_thread = w_thr[DEPTH];
                    end else begin
                        n_res_status = STATUS_NOTFOUND;
                    end
                end
                OP_REMOVE: begin
                    if (q_empty) begin
                        n_res_status = STATUS_EMPTY;
                    end else if (seen_id[DEPTH]) begin
                        cmd.kind = CK_DEL_ID;
                        n_count  = r_count - CNT_W'(1);
                    end else begin
                        n_res_status = STATUS_NOTFOUND;
                    end
                end
                OP_UPDATE: begin
                    if (q_empty) begin
                        n_res_status = STATUS_EMPTY;
                    end else if (seen_id[DEPTH]) begin
                        cmd.kind = CK_UPDATE;
                    end else begin
                        n_res_status = STATUS_NOTFOUND;
                    end
                end
                OP_LOOKUP: begin
                    if (q_empty) begin
                        n_res_status = STATUS_EMPTY;
                    end else if (seen_id[DEPTH]) begin
                        n_res_found = 1'b1;
                        n_res_state = id_st[DEPTH];
                    end else begin
                        n_res_status = STATUS_NOTFOUND;
                    end
                end
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_fsm       = r_fsm;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_fsm)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_fsm = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_fsm = ST_SUM;
            end
            ST_SUM: begin
                if (sum_go) begin
                    n_out_valid = 1'b1;
                    n_fsm       = in_xfer ? ST_EXEC : ST_IDLE;
                end
            end
            default: begin
                n_fsm = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op        <= i_in.op;
            r_id        <= i_in.thread_id;
            r_set_state <= i_in.set_state;
        end
        if (r_fsm == ST_EXEC) begin
            r_res_status <= n_res_status;
            r_res_thread <= n_res_thread;
            r_res_state  <= n_res_state;
            r_res_found  <= n_res_found;
        end
    end

    // summary over the updated row
    assign front_id    = q_empty ? '0 : c_thread[0];
    assign ext_front   = EXT_W'(front_id);
    assign ext_fwait   = EXT_W'(w_thr[DEPTH]);
    assign ext_rthread = EXT_W'(r_res_thread);

    always_ff @(posedge i_clk) begin
        if (sum_go) begin
            r_o_status      <= r_res_status;
            r_o_rthread     <= ext_rthread[OUT_ID_W-1:0];
            r_o_rstate      <= r_res_state;
            r_o_found       <= r_res_found;
            r_o_empty       <= q_empty;
            r_o_count       <= r_count;
            r_o_front       <= ext_front[OUT_ID_W-1:0];
            r_o_fwait       <= ext_fwait[OUT_ID_W-1:0];
            r_o_fwait_valid <= seen_wait[DEPTH];
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.status              = r_o_status;
    assign o_out.result_thread       = r_o_rthread;
    assign o_out.result_state        = r_o_rstate;
    assign o_out.found               = r_o_found;
    assign o_out.queue_empty         = r_o_empty;
    assign o_out.entry_count         = r_o_count;
    assign o_out.front_thread        = r_o_front;
    assign o_out.first_waiting       = r_o_fwait;
    assign o_out.first_waiting_valid = r_o_fwait_valid;

    // register port; decoded on the word address, byte lanes ignored
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = paddr[APB_ADDR_W-1:2] == ADDR_WAIT_CODE[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_code <= WAIT_CODE_RST;
        end else if (cfg_wr && cfg_sel) begin
            r_wait_code <= pwdata[ST_W-1:0];
        end
    end

    assign prdata = cfg_sel ? APB_DATA_W'(r_wait_code) : '0;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count)) || (r_count == $past(r_count) + CNT_W'(1))
        || (r_count == $past(r_count) - CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_fsm == ST_EXEC))
        else $error("accepted item did not enter execute step");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_fsm) == ST_SUM))
        else $error("result raised outside summary step");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_empty == (r_o_count == '0)))
        else $error("empty flag disagrees with count");
`endif

endmodule

/* design/kwq_cell.sv */
module kwq_cell #(
    parameter int ID_W  = kwq_pkg::ID_BITS_DEF,
    parameter int CNT_W = $clog2(kwq_pkg::DEPTH_DEF + 1),
    parameter int IDX   = 0
) (
    input  logic                     i_clk,
    input  kwq_pkg::t_cell_cmd       i_cmd,
    input  logic [CNT_W-1:0]         i_count,
    input  logic [ID_W-1:0]          i_id,
    input  logic [ID_W-1:0]          i_next_thread,
    input  logic [kwq_pkg::ST_W-1:0] i_next_state,
    input  logic                     i_seen_id,
    input  logic                     i_seen_wait,
    input  logic [ID_W-1:0]          i_wait_thread,
    input  logic [kwq_pkg::ST_W-1:0] i_id_state,
    output logic [ID_W-1:0]          o_thread,
    output logic [kwq_pkg::ST_W-1:0] o_state,
    output logic                     o_seen_id,
    output logic                     o_seen_wait,
    output logic [ID_W-1:0]          o_wait_thread,
    output logic [kwq_pkg::ST_W-1:0] o_id_state
);
    import kwq_pkg::*;

    logic [ID_W-1:0] r_thread;
    logic [ST_W-1:0] r_state;
    logic            occ;
    logic            m_id;
    logic            m_wait;
    logic            hit_id;
    logic            hit_wait;
    logic            tail;

    assign occ      = i_count > CNT_W'(IDX);
    assign tail     = i_count == CNT_W'(IDX);
    assign m_id     = occ && (r_thread == i_id);
    assign m_wait   = occ && (r_state == i_cmd.wait_code);
    assign hit_id   = m_id && !i_seen_id;
    assign hit_wait = m_wait && !i_seen_wait;

    // oldest-match chains
    assign o_seen_id     = i_seen_id | m_id;
    assign o_seen_wait   = i_seen_wait | m_wait;
    assign o_wait_thread = hit_wait ? r_thread : i_wait_thread;
    assign o_id_state    = hit_id ? r_state : i_id_state;

    assign o_thread = r_thread;
    assign o_state  = r_state;

    always_ff @(posedge i_clk) begin
        case (i_cmd.kind)
            CK_APPEND: begin
                if (tail) begin
                    r_thread <= i_id;
                    r_state  <= i_cmd.set_state;
                end
            end
            // at and behind the removed entry, pull from the neighbour
            CK_DEL_ID: begin
                if (o_seen_id) begin
                    r_thread <= i_next_thread;
                    r_state  <= i_next_state;
                end
            end
            CK_DEL_WAIT: begin
                if (o_seen_wait) begin
                    r_thread <= i_next_thread;
                    r_state  <= i_next_state;
                end
            end
            CK_UPDATE: begin
                if (hit_id) begin
                    r_state <= i_cmd.set_state;
                end
            end
            default: ;
        endcase
    end

endmodule
